// ===== hdl/scc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int NODE_W            = 6;
  localparam int CNT_W             = 7;
  localparam int NODES             = 64;
  localparam int WALK_W            = NODE_W + CNT_W;
  localparam int MAX_NODES_DEFAULT = 64;
  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_RUN    = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_P0_OUTER,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP_WAIT,
    ST_P1_OUTER,
    ST_P1_WAIT
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [NODES-1:0]  wr_data;
    logic              clr;
  } adj_req_t;

endpackage

// ===== hdl/scc_adj.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_adj
// Adjacency row memory, one row per node, with per-row valid bits so that
// reset and clear empty every row at once. Registered read.
// ----------------------------------------------------------------------------
module scc_adj
  import scc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  adj_req_t         req,
  output logic [NODES-1:0] rd_data
);

  logic [NODES-1:0] mem [NODES];
  logic [NODES-1:0] row_valid;
  logic [NODES-1:0] rd_q;
  logic             rd_valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (req.clr) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q       <= mem[req.rd_addr];
      rd_valid_q <= row_valid[req.rd_addr];
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ===== hdl/scc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer for edge edits and the two depth-first passes. Each neighbor
// test is an adjacency read state followed by a check state through the
// shared scan compare; finish and walk stacks are local memories.
// ----------------------------------------------------------------------------
module scc_ctrl
  import scc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  input  logic [CNT_W-1:0]  node_lim,
  input  logic [CNT_W-1:0]  run_n,
  input  logic [NODES-1:0]  adj_rdata,
  output adj_req_t          adj_req,
  output logic              busy,
  output logic              result_valid,
  output logic [NODE_W-1:0] node_id,
  output logic [NODE_W-1:0] component_id,
  output logic              last
);

  state_t            state, state_next;
  logic              pass, pass_next;
  logic [CNT_W-1:0]  s, s_next;
  logic [NODE_W-1:0] v, v_next;
  logic [CNT_W-1:0]  j, j_next;
  logic [CNT_W-1:0]  depth, depth_next;
  logic [CNT_W-1:0]  fcount, fcount_next;
  logic [NODE_W-1:0] comp, comp_next;
  logic [CNT_W-1:0]  emit_cnt, emit_cnt_next;
  logic [NODES-1:0]  visited, visited_next;
  func_t             op, op_next;
  logic [NODE_W-1:0] fnode, fnode_next;
  logic [NODE_W-1:0] tnode, tnode_next;

  logic [NODE_W-1:0] fmem [NODES];
  logic [WALK_W-1:0] wmem [NODES];
  logic [NODE_W-1:0] fmem_q;
  logic [WALK_W-1:0] wmem_q;

  logic              fw_en, frd_en, ww_en, wrd_en;
  logic [NODE_W-1:0] fw_addr, frd_addr, ww_addr, wrd_addr;
  logic [NODE_W-1:0] fw_data;
  logic [WALK_W-1:0] ww_data;
  logic              emit;
  logic [NODE_W-1:0] emit_node;
  logic              rbit, hit;
  logic [NODES-1:0]  tmask;

  assign tmask = {{(NODES-1){1'b0}}, 1'b1} << tnode;
  assign rbit  = pass ? adj_rdata[v] : adj_rdata[j[NODE_W-1:0]];
  assign hit   = rbit && (j[NODE_W-1:0] != v) && !visited[j[NODE_W-1:0]];
  assign busy  = (state != ST_IDLE);

  always_comb begin
    state_next    = state;
    pass_next     = pass;
    s_next        = s;
    v_next        = v;
    j_next        = j;
    depth_next    = depth;
    fcount_next   = fcount;
    comp_next     = comp;
    emit_cnt_next = emit_cnt;
    visited_next  = visited;
    op_next       = op;
    fnode_next    = fnode;
    tnode_next    = tnode;
    adj_req       = '0;
    fw_en         = 1'b0;
    fw_addr       = fcount[NODE_W-1:0];
    fw_data       = v;
    frd_en        = 1'b0;
    frd_addr      = '0;
    ww_en         = 1'b0;
    ww_addr       = depth[NODE_W-1:0];
    ww_data       = {v, j + 7'd1};
    wrd_en        = 1'b0;
    wrd_addr      = '0;
    emit          = 1'b0;
    emit_node     = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          op_next    = func_t'(func);
          fnode_next = from_node;
          tnode_next = to_node;
          case (func_t'(func))
            FUNC_ADD, FUNC_REMOVE: begin
              if ({1'b0, from_node} < node_lim && {1'b0, to_node} < node_lim) begin
                state_next = ST_EDGE_RD;
              end
            end
            FUNC_CLEAR: begin
              adj_req.clr = 1'b1;
            end
            FUNC_RUN: begin
              visited_next  = '0;
              fcount_next   = '0;
              comp_next     = '0;
              emit_cnt_next = '0;
              s_next        = '0;
              pass_next     = 1'b0;
              state_next    = ST_P0_OUTER;
            end
            default: ;
          endcase
        end
      end
      ST_EDGE_RD: begin
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = fnode;
        state_next      = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = fnode;
        adj_req.wr_data = (op == FUNC_ADD) ? (adj_rdata | tmask) : (adj_rdata & ~tmask);
        state_next      = ST_IDLE;
      end
      ST_P0_OUTER: begin
        if (s >= run_n) begin
          visited_next = '0;
          pass_next    = 1'b1;
          state_next   = ST_P1_OUTER;
        end else begin
          s_next = s + 7'd1;
          if (!visited[s[NODE_W-1:0]]) begin
            visited_next[s[NODE_W-1:0]] = 1'b1;
            v_next     = s[NODE_W-1:0];
            j_next     = '0;
            depth_next = '0;
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (j >= run_n) begin
          if (!pass) begin
            fw_en       = 1'b1;
            fcount_next = fcount + 7'd1;
          end
          if (depth == '0) begin
            if (pass) begin
              comp_next  = comp + 6'd1;
              state_next = ST_P1_OUTER;
            end else begin
              state_next = ST_P0_OUTER;
            end
          end else begin
            wrd_en     = 1'b1;
            wrd_addr   = depth[NODE_W-1:0] - 6'd1;
            depth_next = depth - 7'd1;
            state_next = ST_POP_WAIT;
          end
        end else begin
          adj_req.rd_en   = 1'b1;
          adj_req.rd_addr = pass ? j[NODE_W-1:0] : v;
          state_next      = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (hit) begin
          ww_en      = 1'b1;
          depth_next = depth + 7'd1;
          visited_next[j[NODE_W-1:0]] = 1'b1;
          if (pass) begin
            emit          = 1'b1;
            emit_node     = j[NODE_W-1:0];
            emit_cnt_next = emit_cnt + 7'd1;
          end
          v_next = j[NODE_W-1:0];
          j_next = '0;
        end else begin
          j_next = j + 7'd1;
        end
        state_next = ST_SCAN_RD;
      end
      ST_POP_WAIT: begin
        v_next     = wmem_q[WALK_W-1:CNT_W];
        j_next     = wmem_q[CNT_W-1:0];
        state_next = ST_SCAN_RD;
      end
      ST_P1_OUTER: begin
        if (fcount == '0) begin
          state_next = ST_IDLE;
        end else begin
          frd_en      = 1'b1;
          frd_addr    = fcount[NODE_W-1:0] - 6'd1;
          fcount_next = fcount - 7'd1;
          state_next  = ST_P1_WAIT;
        end
      end
      ST_P1_WAIT: begin
        if (visited[fmem_q]) begin
          state_next = ST_P1_OUTER;
        end else begin
          visited_next[fmem_q] = 1'b1;
          emit          = 1'b1;
          emit_node     = fmem_q;
          emit_cnt_next = emit_cnt + 7'd1;
          v_next        = fmem_q;
          j_next        = '0;
          depth_next    = '0;
          state_next    = ST_SCAN_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      fcount       <= '0;
      depth        <= '0;
      comp         <= '0;
      emit_cnt     <= '0;
      visited      <= '0;
      pass         <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      fcount       <= fcount_next;
      depth        <= depth_next;
      comp         <= comp_next;
      emit_cnt     <= emit_cnt_next;
      visited      <= visited_next;
      pass         <= pass_next;
    end
  end

  always_ff @(posedge clk) begin
    s     <= s_next;
    v     <= v_next;
    j     <= j_next;
    op    <= op_next;
    fnode <= fnode_next;
    tnode <= tnode_next;
    if (emit) begin
      node_id      <= emit_node;
      component_id <= comp;
      last         <= (emit_cnt == run_n - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      fmem[fw_addr] <= fw_data;
    end
    if (frd_en) begin
      fmem_q <= fmem[frd_addr];
    end
    if (ww_en) begin
      wmem[ww_addr] <= ww_data;
    end
    if (wrd_en) begin
      wmem_q <= wmem[wrd_addr];
    end
  end

endmodule

// ===== hdl/strongly_connected_components.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongly_connected_components
// Edge edits and two-pass depth-first component decomposition on a
// bit-matrix graph. An edit reads the source row, then writes it back. In
// each pass a neighbor test is a read on the adjacency read port followed
// by a check in the shared scan compare; busy is high during a run.
// Results come out one per strobe and cannot be stalled. Reset (rst,
// synchronous) empties the graph and sets node_count to 64.
// ----------------------------------------------------------------------------
module strongly_connected_components
  import scc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              result_valid,
  output logic [NODE_W-1:0] node_id,
  output logic [NODE_W-1:0] component_id,
  output logic              last
);

  localparam int LIMIT = (MAX_NODES < NODES) ? MAX_NODES : NODES;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] run_n;
  adj_req_t         adj_req;
  logic [NODES-1:0] adj_rdata;

  assign cfg_ready = !busy;
  assign run_n     = (node_count > LIMIT_C) ? LIMIT_C : node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  scc_adj u_adj (
    .clk     (clk),
    .rst     (rst),
    .req     (adj_req),
    .rd_data (adj_rdata)
  );

  scc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .from_node    (from_node),
    .to_node      (to_node),
    .node_lim     (LIMIT_C),
    .run_n        (run_n),
    .adj_rdata    (adj_rdata),
    .adj_req      (adj_req),
    .busy         (busy),
    .result_valid (result_valid),
    .node_id      (node_id),
    .component_id (component_id),
    .last         (last)
  );

endmodule

// ===== hdl/scc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks for the strongly connected components block.
// ----------------------------------------------------------------------------
module scc_checker
  import scc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              result_valid,
  input logic              last,
  input logic [NODE_W-1:0] component_id
);

  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside a run");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !result_valid) else $error("result right after idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid) else $error("result after last");

  a_comp_mono: assert property (@(posedge clk) disable iff (rst)
    result_valid && $past(result_valid) && $past(busy) |->
      (component_id == $past(component_id) || component_id == $past(component_id) + 6'd1))
    else $error("component number jumped");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .last         (last),
  .component_id (component_id)
);
